// ===== rtl/v3alu_pkg.sv =====
`default_nettype none

package v3alu_pkg;

    typedef enum logic [4:0] {
        ACT_ADD     = 5'd0,
        ACT_SUB     = 5'd1,
        ACT_MUL     = 5'd2,
        ACT_DIV     = 5'd3,
        ACT_SADD    = 5'd4,
        ACT_SSUB    = 5'd5,
        ACT_SMUL    = 5'd6,
        ACT_SDIV    = 5'd7,
        ACT_CROSS   = 5'd8,
        ACT_DOT     = 5'd9,
        ACT_LENGTH  = 5'd10,
        ACT_NORM    = 5'd11,
        ACT_REFLECT = 5'd12,
        ACT_EQ      = 5'd13,
        ACT_NE      = 5'd14,
        ACT_LE      = 5'd15,
        ACT_GE      = 5'd16
    } action_t;

    localparam int FX_W        = 32;
    localparam int PROD_W      = 2 * FX_W;
    localparam int SAT_W       = 72;
    localparam int SQRT_STAGES = FX_W;

    typedef logic signed [FX_W-1:0]   fx_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    localparam fx_t FX_MAX = fx_t'(32'h7fff_ffff);
    localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(FX_MAX);

    typedef struct packed {
        logic [4:0]   act;
        fx_t  [2:0]   a;
        fx_t  [2:0]   b;
        fx_t          s;
    } item_t;

    typedef struct packed {
        item_t        item;
        fx_t  [2:0]   r;
        fx_t          sc;
        logic         cmp;
    } side_t;

    typedef struct packed {
        fx_t  [2:0]   r;
        fx_t          sc;
        logic         cmp;
        logic         isdiv;
        logic [2:0]   neg;
    } tail_t;

    function automatic fx_t sat_fx(input logic signed [SAT_W-1:0] v);
        if (v > SAT_HI) begin
            return FX_MAX;
        end else if (v < ~SAT_HI) begin
            return ~FX_MAX;
        end
        return v[FX_W-1:0];
    endfunction

    function automatic logic [FX_W-1:0] abs_fx(input fx_t v);
        if (v[FX_W-1]) begin
            return $unsigned(-v);
        end
        return $unsigned(v);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/v3alu_lane.sv =====
`default_nettype none

module v3alu_lane (
    input  wire logic            aclk,
    input  wire logic            en,
    input  wire logic [4:0]      act,
    input  v3alu_pkg::fx_t       a_i,
    input  v3alu_pkg::fx_t       a_j,
    input  v3alu_pkg::fx_t       a_k,
    input  v3alu_pkg::fx_t       b_i,
    input  v3alu_pkg::fx_t       b_j,
    input  v3alu_pkg::fx_t       b_k,
    input  v3alu_pkg::fx_t       s,
    output v3alu_pkg::prod_t     p1,
    output v3alu_pkg::prod_t     p2
);
    import v3alu_pkg::*;

    fx_t   x;
    fx_t   y;
    prod_t p1_reg;
    prod_t p1_next;
    prod_t p2_reg;
    prod_t p2_next;

    always_comb begin
        case (act) inside
            ACT_CROSS: begin
                x = a_j;
                y = b_k;
            end
            ACT_SMUL: begin
                x = a_i;
                y = s;
            end
            ACT_LENGTH, ACT_NORM: begin
                x = a_i;
                y = a_i;
            end
            default: begin
                x = a_i;
                y = b_i;
            end
        endcase
        p1_next = x * y;
        p2_next = a_k * b_j;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg <= p1_next;
            p2_reg <= p2_next;
        end
    end

    assign p1 = p1_reg;
    assign p2 = p2_reg;

endmodule

`default_nettype wire

// ===== rtl/v3alu_sqrt.sv =====
`default_nettype none

module v3alu_sqrt (
    input  wire logic                                   aclk,
    input  wire logic                                   en,
    input  wire logic [2*v3alu_pkg::SQRT_STAGES-1:0]    rad,
    output logic      [v3alu_pkg::SQRT_STAGES-1:0]      root
);
    import v3alu_pkg::*;

    localparam int RAD_W  = 2 * SQRT_STAGES;
    localparam int ROOT_W = SQRT_STAGES;
    localparam int REM_W  = ROOT_W + 3;

    logic [REM_W-1:0]  rem_reg   [SQRT_STAGES];
    logic [ROOT_W-1:0] root_reg  [SQRT_STAGES];
    logic [RAD_W-1:0]  rad_reg   [SQRT_STAGES];
    logic [REM_W-1:0]  rem_next  [SQRT_STAGES];
    logic [ROOT_W-1:0] root_next [SQRT_STAGES];
    logic [RAD_W-1:0]  rad_next  [SQRT_STAGES];
    logic [REM_W-1:0]  rem_prev  [SQRT_STAGES];
    logic [ROOT_W-1:0] root_prev [SQRT_STAGES];
    logic [RAD_W-1:0]  rad_prev  [SQRT_STAGES];
    logic [REM_W-1:0]  rem_t     [SQRT_STAGES];
    logic [REM_W-1:0]  trial     [SQRT_STAGES];

    // Each stage brings down two radicand bits and settles one root bit.
    always_comb begin
        for (int k = 0; k < SQRT_STAGES; k++) begin
            if (k == 0) begin
                rem_prev[k]  = '0;
                root_prev[k] = '0;
                rad_prev[k]  = rad;
            end else begin
                rem_prev[k]  = rem_reg[k-1];
                root_prev[k] = root_reg[k-1];
                rad_prev[k]  = rad_reg[k-1];
            end
            rem_t[k] = {rem_prev[k][REM_W-3:0], rad_prev[k][RAD_W-1 -: 2]};
            trial[k] = {1'b0, root_prev[k], 2'b01};
            if (rem_t[k] >= trial[k]) begin
                rem_next[k]  = rem_t[k] - trial[k];
                root_next[k] = {root_prev[k][ROOT_W-2:0], 1'b1};
            end else begin
                rem_next[k]  = rem_t[k];
                root_next[k] = {root_prev[k][ROOT_W-2:0], 1'b0};
            end
            rad_next[k] = {rad_prev[k][RAD_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < SQRT_STAGES; k++) begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                rad_reg[k]  <= rad_next[k];
            end
        end
    end

    assign root = root_reg[SQRT_STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/v3alu_div.sv =====
`default_nettype none

module v3alu_div #(
    parameter int QUO_W = 48
) (
    input  wire logic                        aclk,
    input  wire logic                        en,
    input  wire logic [v3alu_pkg::FX_W-1:0]  mag,
    input  wire logic [v3alu_pkg::FX_W-1:0]  dvs,
    output logic      [QUO_W-1:0]            quo
);
    import v3alu_pkg::*;

    logic [FX_W-1:0]  rem_reg  [QUO_W];
    logic [QUO_W-1:0] sh_reg   [QUO_W];
    logic [FX_W-1:0]  dvs_reg  [QUO_W];
    logic [FX_W-1:0]  rem_next [QUO_W];
    logic [QUO_W-1:0] sh_next  [QUO_W];
    logic [FX_W-1:0]  rem_prev [QUO_W];
    logic [QUO_W-1:0] sh_prev  [QUO_W];
    logic [FX_W-1:0]  dvs_prev [QUO_W];
    logic [FX_W:0]    rem_t    [QUO_W];
    logic [FX_W:0]    diff     [QUO_W];
    logic             ge       [QUO_W];

    // The dividend enters scaled by the fraction bits; the quotient shifts in
    // behind it, one bit per stage.
    always_comb begin
        for (int k = 0; k < QUO_W; k++) begin
            if (k == 0) begin
                rem_prev[k] = '0;
                sh_prev[k]  = {mag, {(QUO_W-FX_W){1'b0}}};
                dvs_prev[k] = dvs;
            end else begin
                rem_prev[k] = rem_reg[k-1];
                sh_prev[k]  = sh_reg[k-1];
                dvs_prev[k] = dvs_reg[k-1];
            end
            rem_t[k] = {rem_prev[k], sh_prev[k][QUO_W-1]};
            diff[k]  = rem_t[k] - {1'b0, dvs_prev[k]};
            ge[k]    = rem_t[k] >= {1'b0, dvs_prev[k]};
            rem_next[k] = ge[k] ? diff[k][FX_W-1:0] : rem_t[k][FX_W-1:0];
            sh_next[k]  = {sh_prev[k][QUO_W-2:0], ge[k]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < QUO_W; k++) begin
                rem_reg[k] <= rem_next[k];
                sh_reg[k]  <= sh_next[k];
                dvs_reg[k] <= dvs_prev[k];
            end
        end
    end

    assign quo = sh_reg[QUO_W-1];

endmodule

`default_nettype wire

// ===== rtl/vector3_alu_top.sv =====
`default_nettype none

// Operands and results are signed fixed point, Q16.16 for the default FRAC_BITS.
// Throughput: one item per cycle unless m_ready stalls the output; the square root and the three dividers are
// fully pipelined, one root bit and one quotient bit per stage.
// The whole pipeline holds while a result waits on m_ready.
// Reset clears only the valid bits; the data path is not reset.

module vector3_alu_top #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [4:0]             s_action,
    input  wire logic signed [31:0]     s_ax,
    input  wire logic signed [31:0]     s_ay,
    input  wire logic signed [31:0]     s_az,
    input  wire logic signed [31:0]     s_bx,
    input  wire logic signed [31:0]     s_by,
    input  wire logic signed [31:0]     s_bz,
    input  wire logic signed [31:0]     s_scalar_in,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic signed [31:0]          m_rx,
    output logic signed [31:0]          m_ry,
    output logic signed [31:0]          m_rz,
    output logic signed [31:0]          m_scalar_out,
    output logic                        m_compare_true
);
    import v3alu_pkg::*;

    localparam int QUO_W = FX_W + FRAC_BITS;
    localparam int DEPTH = 7 + SQRT_STAGES + QUO_W;
    localparam logic [FX_W-1:0] ONE_FX = FX_W'(64'd1 << FRAC_BITS);

    logic                    en;
    logic [DEPTH-1:0]        vld_reg;
    logic [DEPTH-1:0]        vld_next;

    item_t                   it0_reg;
    item_t                   it1_reg;
    prod_t                   p1 [3];
    prod_t                   p2 [3];

    logic signed [SAT_W-1:0]  dsum;
    fx_t                      dsat;
    logic [PROD_W-1:0]        sumsq_next;
    logic signed [PROD_W:0]   diff [3];
    logic signed [SAT_W-1:0]  lane_val [3];
    logic                     all_eq;
    logic                     all_le;
    logic                     all_ge;
    side_t                    side2_next;
    side_t                    side2_reg;
    fx_t                      d2_reg;
    logic [PROD_W-1:0]        sumsq2_reg;

    prod_t                    q_next [3];
    prod_t                    q3_reg [3];
    side_t                    side3_reg;
    logic [PROD_W-1:0]        sumsq3_reg;

    logic signed [SAT_W-1:0]  refl [3];
    side_t                    side4_next;
    side_t                    side4_reg;
    logic [PROD_W-1:0]        sumsq4_reg;

    side_t                    sdel_reg [SQRT_STAGES];
    logic [FX_W-1:0]          root;

    side_t                    sp;
    logic [FX_W-1:0]          len1;
    logic                     bzero;
    logic                     szero;
    logic [FX_W-1:0]          mag_next [3];
    logic [FX_W-1:0]          dvs_next [3];
    logic [FX_W-1:0]          mag_reg  [3];
    logic [FX_W-1:0]          dvs_reg  [3];
    tail_t                    tail_next;
    tail_t                    tail_reg;

    tail_t                    tdel_reg [QUO_W];
    logic [QUO_W-1:0]         quo [3];
    tail_t                    tl;
    logic signed [SAT_W-1:0]  qs [3];
    fx_t                      r_out [3];

    fx_t                      rx_reg;
    fx_t                      ry_reg;
    fx_t                      rz_reg;
    fx_t                      sc_reg;
    logic                     cmp_reg;

    assign en      = !m_valid || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[DEPTH-1];
    assign vld_next = {vld_reg[DEPTH-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_lane
        v3alu_lane u_lane (
            .aclk (aclk),
            .en   (en),
            .act  (it0_reg.act),
            .a_i  (it0_reg.a[i]),
            .a_j  (it0_reg.a[(i+1)%3]),
            .a_k  (it0_reg.a[(i+2)%3]),
            .b_i  (it0_reg.b[i]),
            .b_j  (it0_reg.b[(i+1)%3]),
            .b_k  (it0_reg.b[(i+2)%3]),
            .s    (it0_reg.s),
            .p1   (p1[i]),
            .p2   (p2[i])
        );
    end

    // Merges lane products into dot sum and sum of squares; also forms element results and compares.
    always_comb begin
        dsum = SAT_W'(p1[0]) + SAT_W'(p1[1]) + SAT_W'(p1[2]);
        dsat = sat_fx(dsum >>> FRAC_BITS);
        sumsq_next = $unsigned(p1[0]) + $unsigned(p1[1]) + $unsigned(p1[2]);
        all_eq = 1'b1;
        all_le = 1'b1;
        all_ge = 1'b1;
        side2_next.item = it1_reg;
        for (int i = 0; i < 3; i++) begin
            diff[i] = (PROD_W+1)'(p1[i]) - (PROD_W+1)'(p2[i]);
            case (it1_reg.act) inside
                ACT_ADD:  lane_val[i] = SAT_W'($signed(it1_reg.a[i]))
                                      + SAT_W'($signed(it1_reg.b[i]));
                ACT_SUB:  lane_val[i] = SAT_W'($signed(it1_reg.a[i]))
                                      - SAT_W'($signed(it1_reg.b[i]));
                ACT_SADD: lane_val[i] = SAT_W'($signed(it1_reg.a[i]))
                                      + SAT_W'($signed(it1_reg.s));
                ACT_SSUB: lane_val[i] = SAT_W'($signed(it1_reg.a[i]))
                                      - SAT_W'($signed(it1_reg.s));
                ACT_MUL, ACT_SMUL: lane_val[i] = SAT_W'(p1[i] >>> FRAC_BITS);
                ACT_DIV, ACT_SDIV: lane_val[i] = SAT_W'($signed(it1_reg.a[i]));
                ACT_CROSS: lane_val[i] = SAT_W'(diff[i] >>> FRAC_BITS);
                default:  lane_val[i] = '0;
            endcase
            side2_next.r[i] = sat_fx(lane_val[i]);
            all_eq = all_eq && ($signed(it1_reg.a[i]) == $signed(it1_reg.b[i]));
            all_le = all_le && ($signed(it1_reg.a[i]) <= $signed(it1_reg.b[i]));
            all_ge = all_ge && ($signed(it1_reg.a[i]) >= $signed(it1_reg.b[i]));
        end
        case (it1_reg.act) inside
            ACT_DOT, ACT_REFLECT: side2_next.sc = dsat;
            default:              side2_next.sc = '0;
        endcase
        case (it1_reg.act)
            ACT_EQ:  side2_next.cmp = all_eq;
            ACT_NE:  side2_next.cmp = !all_eq;
            ACT_LE:  side2_next.cmp = all_le;
            ACT_GE:  side2_next.cmp = all_ge;
            default: side2_next.cmp = 1'b0;
        endcase
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            q_next[i] = $signed(side2_reg.item.b[i]) * d2_reg;
        end
    end

    always_comb begin
        side4_next = side3_reg;
        for (int i = 0; i < 3; i++) begin
            refl[i] = SAT_W'($signed(side3_reg.item.a[i]))
                    - (SAT_W'(q3_reg[i] >>> FRAC_BITS) <<< 1);
            if (side3_reg.item.act == ACT_REFLECT) begin
                side4_next.r[i] = sat_fx(refl[i]);
            end
        end
    end

    v3alu_sqrt u_sqrt (
        .aclk (aclk),
        .en   (en),
        .rad  (sumsq4_reg),
        .root (root)
    );

    // Divisor and sign selection once the length is known; LENGTH takes the root as its scalar.
    always_comb begin
        sp    = sdel_reg[SQRT_STAGES-1];
        len1  = (root == '0) ? ONE_FX : root;
        bzero = (sp.item.b[0] == '0) || (sp.item.b[1] == '0) || (sp.item.b[2] == '0);
        szero = (sp.item.s == '0);
        tail_next.r   = sp.r;
        tail_next.cmp = sp.cmp;
        if (sp.item.act == ACT_LENGTH) begin
            tail_next.sc = root[FX_W-1] ? FX_MAX : root;
        end else begin
            tail_next.sc = sp.sc;
        end
        tail_next.isdiv = ((sp.item.act == ACT_DIV) && !bzero)
                       || ((sp.item.act == ACT_SDIV) && !szero)
                       || (sp.item.act == ACT_NORM);
        for (int i = 0; i < 3; i++) begin
            mag_next[i] = abs_fx(sp.item.a[i]);
            case (sp.item.act)
                ACT_DIV: begin
                    dvs_next[i]      = abs_fx(sp.item.b[i]);
                    tail_next.neg[i] = sp.item.a[i][FX_W-1] ^ sp.item.b[i][FX_W-1];
                end
                ACT_SDIV: begin
                    dvs_next[i]      = abs_fx(sp.item.s);
                    tail_next.neg[i] = sp.item.a[i][FX_W-1] ^ sp.item.s[FX_W-1];
                end
                ACT_NORM: begin
                    dvs_next[i]      = len1;
                    tail_next.neg[i] = sp.item.a[i][FX_W-1];
                end
                default: begin
                    dvs_next[i]      = len1;
                    tail_next.neg[i] = 1'b0;
                end
            endcase
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_div
        v3alu_div #(
            .QUO_W (QUO_W)
        ) u_div (
            .aclk (aclk),
            .en   (en),
            .mag  (mag_reg[i]),
            .dvs  (dvs_reg[i]),
            .quo  (quo[i])
        );
    end

    always_comb begin
        tl = tdel_reg[QUO_W-1];
        for (int i = 0; i < 3; i++) begin
            qs[i]    = tl.neg[i] ? -SAT_W'(quo[i]) : SAT_W'(quo[i]);
            r_out[i] = tl.isdiv ? sat_fx(qs[i]) : tl.r[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            it0_reg.act <= s_action;
            it0_reg.a   <= {s_az, s_ay, s_ax};
            it0_reg.b   <= {s_bz, s_by, s_bx};
            it0_reg.s   <= s_scalar_in;
            it1_reg     <= it0_reg;
            side2_reg   <= side2_next;
            d2_reg      <= dsat;
            sumsq2_reg  <= sumsq_next;
            side3_reg   <= side2_reg;
            sumsq3_reg  <= sumsq2_reg;
            for (int i = 0; i < 3; i++) begin
                q3_reg[i]  <= q_next[i];
                mag_reg[i] <= mag_next[i];
                dvs_reg[i] <= dvs_next[i];
            end
            side4_reg   <= side4_next;
            sumsq4_reg  <= sumsq3_reg;
            sdel_reg[0] <= side4_reg;
            for (int k = 1; k < SQRT_STAGES; k++) begin
                sdel_reg[k] <= sdel_reg[k-1];
            end
            tail_reg    <= tail_next;
            tdel_reg[0] <= tail_reg;
            for (int k = 1; k < QUO_W; k++) begin
                tdel_reg[k] <= tdel_reg[k-1];
            end
            rx_reg  <= r_out[0];
            ry_reg  <= r_out[1];
            rz_reg  <= r_out[2];
            sc_reg  <= tl.sc;
            cmp_reg <= tl.cmp;
        end
    end

    assign m_rx           = rx_reg;
    assign m_ry           = ry_reg;
    assign m_rz           = rz_reg;
    assign m_scalar_out   = sc_reg;
    assign m_compare_true = cmp_reg;

endmodule

`default_nettype wire

// ===== tb/tb_vector3_alu_top.sv =====
`default_nettype none

module tb_vector3_alu_top;
    import v3alu_pkg::*;

    localparam int FB = 16;
    localparam longint S_MAX = 64'sd2147483647;
    localparam longint S_MIN = -64'sd2147483648;

    typedef struct {
        logic [4:0] act;
        logic signed [31:0] a [3];
        logic signed [31:0] b [3];
        logic signed [31:0] s;
    } vec_item_t;

    typedef struct {
        logic signed [31:0] r [3];
        logic signed [31:0] sc;
        logic cmp;
    } vec_result_t;

    typedef struct {
        vec_item_t item;
        bit known;
        vec_result_t res;
    } stim_row_t;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic [4:0] s_action;
    logic signed [31:0] s_ax, s_ay, s_az, s_bx, s_by, s_bz, s_scalar_in;
    logic m_valid;
    logic m_ready;
    logic signed [31:0] m_rx, m_ry, m_rz, m_scalar_out;
    logic m_compare_true;

    vec_result_t expected_q[$];
    int errors = 0;
    bit calm = 0;

    vector3_alu_top #(.FRAC_BITS(FB)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_ax(s_ax), .s_ay(s_ay), .s_az(s_az),
        .s_bx(s_bx), .s_by(s_by), .s_bz(s_bz), .s_scalar_in(s_scalar_in),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_rx(m_rx), .m_ry(m_ry), .m_rz(m_rz),
        .m_scalar_out(m_scalar_out), .m_compare_true(m_compare_true)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20000000;
        $display("vector3_alu_top: mismatch");
        $finish;
    end

    function automatic logic signed [31:0] sat(input logic signed [127:0] v);
        if (v > S_MAX) begin
            return 32'h7fffffff;
        end else if (v < S_MIN) begin
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    // Arithmetic shift floors toward minus infinity.
    function automatic logic signed [127:0] fl(input logic signed [127:0] p);
        return p >>> FB;
    endfunction

    // Signed division truncates toward zero.
    function automatic logic signed [127:0] qdiv(input logic signed [127:0] a,
                                                 input logic signed [127:0] d);
        return (a <<< FB) / d;
    endfunction

    function automatic logic signed [127:0] root(input logic [127:0] n);
        logic [127:0] res, bitv;
        res = 0;
        bitv = 128'd1 << 126;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return $signed(res);
    endfunction

    function automatic vec_result_t predict_alu(input vec_item_t it);
        vec_result_t o;
        logic signed [127:0] a [3], b [3], r [3], s, sc, l, d;
        logic [127:0] sq;
        r[0] = 0; r[1] = 0; r[2] = 0;
        sc = 0;
        o.cmp = 0;
        s = it.s;
        for (int i = 0; i < 3; i++) begin
            a[i] = it.a[i];
            b[i] = it.b[i];
        end
        case (it.act)
            ACT_ADD: for (int i = 0; i < 3; i++) r[i] = a[i] + b[i];
            ACT_SUB: for (int i = 0; i < 3; i++) r[i] = a[i] - b[i];
            ACT_MUL: for (int i = 0; i < 3; i++) r[i] = fl(a[i] * b[i]);
            ACT_DIV: begin
                for (int i = 0; i < 3; i++) begin
                    if (b[0] != 0 && b[1] != 0 && b[2] != 0) begin
                        r[i] = qdiv(a[i], b[i]);
                    end else begin
                        r[i] = a[i];
                    end
                end
            end
            ACT_SADD: for (int i = 0; i < 3; i++) r[i] = a[i] + s;
            ACT_SSUB: for (int i = 0; i < 3; i++) r[i] = a[i] - s;
            ACT_SMUL: for (int i = 0; i < 3; i++) r[i] = fl(a[i] * s);
            ACT_SDIV: for (int i = 0; i < 3; i++) r[i] = (s != 0) ? qdiv(a[i], s) : a[i];
            ACT_CROSS: begin
                r[0] = fl(a[1] * b[2] - a[2] * b[1]);
                r[1] = fl(a[2] * b[0] - a[0] * b[2]);
                r[2] = fl(a[0] * b[1] - a[1] * b[0]);
            end
            ACT_DOT: sc = fl(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]);
            ACT_LENGTH: sc = root(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
            ACT_NORM: begin
                l = root(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
                if (l == 0) l = 128'sd1 <<< FB;
                for (int i = 0; i < 3; i++) r[i] = qdiv(a[i], l);
            end
            ACT_REFLECT: begin
                d = sat(fl(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]));
                for (int i = 0; i < 3; i++) r[i] = a[i] - 2 * fl(b[i] * d);
                sc = d;
            end
            ACT_EQ: o.cmp = a[0] == b[0] && a[1] == b[1] && a[2] == b[2];
            ACT_NE: o.cmp = a[0] != b[0] || a[1] != b[1] || a[2] != b[2];
            ACT_LE: o.cmp = a[0] <= b[0] && a[1] <= b[1] && a[2] <= b[2];
            ACT_GE: o.cmp = a[0] >= b[0] && a[1] >= b[1] && a[2] >= b[2];
            default: ;
        endcase
        for (int i = 0; i < 3; i++) o.r[i] = sat(r[i]);
        o.sc = sat(sc);
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("error: %s got %h expected %h", what, got, want);
        errors++;
    endtask

    function automatic logic signed [31:0] rand_fx();
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 0;
            3, 4: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
            5: return $signed($urandom_range(0, 32'h7ffffff)) - 32'sh4000000;
            default: return $urandom;
        endcase
    endfunction

    function automatic vec_item_t rand_item();
        vec_item_t it;
        it.act = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(17, 31))
                                               : 5'($urandom_range(0, 16));
        for (int i = 0; i < 3; i++) begin
            it.a[i] = rand_fx();
            it.b[i] = rand_fx();
        end
        it.s = rand_fx();
        if ($urandom_range(0, 4) == 0) begin
            it.b = it.a;
        end
        return it;
    endfunction

    function automatic vec_item_t mk(input logic [4:0] act, input logic signed [31:0] v,
                                     input logic signed [31:0] w, input logic signed [31:0] s);
        vec_item_t it;
        it.act = act;
        it.a = '{v, v, v};
        it.b = '{w, w, w};
        it.s = s;
        return it;
    endfunction

    task automatic send_item(input vec_item_t it, input bit known, input vec_result_t res);
        while (!calm && $urandom_range(0, 99) < 10) begin
            s_valid <= 0;
            @(negedge aclk);
        end
        s_valid <= 1;
        s_action <= it.act;
        s_ax <= it.a[0]; s_ay <= it.a[1]; s_az <= it.a[2];
        s_bx <= it.b[0]; s_by <= it.b[1]; s_bz <= it.b[2];
        s_scalar_in <= it.s;
        expected_q.push_back(known ? res : predict_alu(it));
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= 10);
    end

    always @(posedge aclk) begin
        vec_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected item", m_rx, 0);
            end else begin
                e = expected_q.pop_front();
                if (m_rx !== e.r[0]) report_mismatch("rx", m_rx, e.r[0]);
                if (m_ry !== e.r[1]) report_mismatch("ry", m_ry, e.r[1]);
                if (m_rz !== e.r[2]) report_mismatch("rz", m_rz, e.r[2]);
                if (m_scalar_out !== e.sc) report_mismatch("scalar_out", m_scalar_out, e.sc);
                if (m_compare_true !== e.cmp) begin
                    report_mismatch("compare_true", m_compare_true, e.cmp);
                end
            end
        end
    end

    initial begin
        stim_row_t rows[$];
        stim_row_t row;
        vec_result_t z;
        vec_item_t it;
        z.r = '{0, 0, 0};
        z.sc = 0;
        z.cmp = 0;
        aresetn = 0;
        s_valid = 0;
        m_ready = 0;
        s_action = 0;
        {s_ax, s_ay, s_az, s_bx, s_by, s_bz, s_scalar_in} = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        row.known = 1;
        row.res = z;
        row.item = mk(ACT_ADD, 0, 0, 0); rows.push_back(row);
        row.res.r = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
        row.item = mk(ACT_ADD, 32'h7fffffff, 32'h7fffffff, 0); rows.push_back(row);
        row.res.r = '{32'h80000000, 32'h80000000, 32'h80000000};
        row.item = mk(ACT_SUB, 32'h80000000, 32'h7fffffff, 0); rows.push_back(row);
        row.res.r = '{32'h10000, 32'h10000, 32'h10000};
        row.item = mk(ACT_DIV, 32'h10000, 0, 0); rows.push_back(row);
        row.item = mk(ACT_SDIV, 32'h10000, 0, 0); rows.push_back(row);
        row.item = mk(ACT_NORM, 0, 0, 0); row.res = z; rows.push_back(row);
        row.item = mk(ACT_EQ, 5, 5, 0); row.res.cmp = 1; rows.push_back(row);
        row.item = mk(5'd31, -1, -1, -1); row.res = z; rows.push_back(row);
        row.known = 0;
        for (int k = ACT_ADD; k <= ACT_GE; k++) begin
            row.item = mk(5'(k), 32'h00018000, -32'sh00030000, 32'h7fffffff);
            row.item.a[1] = 32'h80000000;
            row.item.b[2] = 32'h7fffffff;
            rows.push_back(row);
        end
        foreach (rows[i]) send_item(rows[i].item, rows[i].known, rows[i].res);

        for (int n = 0; n < 650; n++) begin
            calm = (n >= 200 && n < 300);
            if (n == 400) begin
                s_valid <= 0;
                wait (expected_q.size() == 0);
                @(negedge aclk);
            end
            it = rand_item();
            send_item(it, 0, z);
        end
        s_valid <= 0;
        calm = 0;
        wait (expected_q.size() == 0);
        repeat (200) @(posedge aclk);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("vector3_alu_top: match");
        end else begin
            $display("vector3_alu_top: mismatch");
        end
        $finish;
    end
endmodule

`default_nettype wire
